// ===== src/ksa_pkg.sv =====
// Shared widths, a rounding helper and polynomial coefficient tables for the Kelvin
// small-argument evaluator. Depends on nothing; used by ksa_mulr and the top level.
package ksa_pkg;

  // Fixed formats
  localparam int IN_W         = 16;  // argument width
  localparam int OUT_W        = 24;  // result width
  localparam int WF           = 28;  // working fraction bits
  localparam int T_W          = 30;  // t, u, v: magnitude up to 1.0 in Q28
  localparam int ACC_W        = 37;  // polynomial accumulators, below 256.0
  localparam int W_W          = 34;  // ber' bracket, below 32.0
  localparam int IN_FRAC_DEF  = 11;
  localparam int OUT_FRAC_DEF = 16;

  // Round a decimal coefficient given times 1e8 to Q28, nearest
  function automatic logic signed [ACC_W-1:0] cq(input longint n);
    return ACC_W'((n * 64'sd268435456 + 64'sd50000000) / 64'sd100000000);
  endfunction

  // ber: polynomial in t^4, lowest power first
  localparam logic signed [ACC_W-1:0] BER_TAB [8] = '{
    cq(64'sd100000000),  -cq(64'sd6400000000), cq(64'sd11377777774),
    -cq(64'sd3236345652), cq(64'sd264191397),  -cq(64'sd8349609),
    cq(64'sd122552),     -cq(64'sd901)
  };

  // bei / t^2
  localparam logic signed [ACC_W-1:0] BEI_TAB [7] = '{
    cq(64'sd1600000000), -cq(64'sd11377777774), cq(64'sd7281777742),
    -cq(64'sd1056765779), cq(64'sd52185615),    -cq(64'sd1103667),
    cq(64'sd11346)
  };

  // ber' / (x t^2)
  localparam logic signed [ACC_W-1:0] BERP_TAB [7] = '{
    -cq(64'sd400000000), cq(64'sd1422222222), -cq(64'sd606814810),
    cq(64'sd66047849),   -cq(64'sd2609253),   cq(64'sd45957),
    -cq(64'sd394)
  };

  // bei' / x
  localparam logic signed [ACC_W-1:0] BEIP_TAB [7] = '{
    cq(64'sd50000000),    -cq(64'sd1066666666), cq(64'sd1137777772),
    -cq(64'sd231167514),  cq(64'sd14677204),    -cq(64'sd379386),
    cq(64'sd4609)
  };

endpackage

// ===== src/ksa_mulr.sv =====
// Two-stage signed multiply, round-to-nearest (ties away from zero) shift,
// and constant add. Depends on ksa_pkg for default widths.
module ksa_mulr #(
  parameter int AW    = ksa_pkg::ACC_W,
  parameter int BW    = ksa_pkg::T_W,
  parameter int OW    = ksa_pkg::ACC_W,
  parameter int SHIFT = ksa_pkg::WF
) (
  input  logic                 clk_i,
  input  logic signed [AW-1:0] a_i,
  input  logic signed [BW-1:0] b_i,
  input  logic signed [OW-1:0] c_i,
  output logic signed [OW-1:0] y_o
);

  localparam int LO_W = AW / 2;
  localparam int HI_W = AW - LO_W;
  localparam int PL_W = LO_W + 1 + BW;
  localparam int PH_W = HI_W + BW;
  localparam int SW   = (((AW + BW) > (OW + SHIFT)) ? (AW + BW) : (OW + SHIFT)) + 2;
  localparam logic signed [SW-1:0] BIAS_P = SW'(64'sd1 <<< (SHIFT - 1));
  localparam logic signed [SW-1:0] BIAS_N = SW'((64'sd1 <<< (SHIFT - 1)) - 64'sd1);

  logic signed [PL_W-1:0] pl_d, pl_q;
  logic signed [PH_W-1:0] ph_d, ph_q;
  logic                   neg_d, neg_q;
  logic signed [OW-1:0]   c_q;
  logic signed [SW-1:0]   pl_x, ph_x, c_x, bias_x, sum_x;
  logic signed [OW-1:0]   y_d, y_q;

  // Split a into a signed high half and an unsigned low half
  always_comb begin
    pl_d  = $signed({1'b0, a_i[LO_W-1:0]}) * b_i;
    ph_d  = $signed(a_i[AW-1:LO_W]) * b_i;
    neg_d = a_i[AW-1] ^ b_i[BW-1];
  end

  // Hold partial products
  always_ff @(posedge clk_i) begin
    pl_q  <= pl_d;
    ph_q  <= ph_d;
    neg_q <= neg_d;
    c_q   <= c_i;
  end

  // Recombine, round on the magnitude, and add the constant above the cut
  always_comb begin
    pl_x   = SW'(pl_q);
    ph_x   = SW'(ph_q);
    c_x    = SW'(c_q) <<< SHIFT;
    bias_x = neg_q ? BIAS_N : BIAS_P;
    sum_x  = (ph_x <<< LO_W) + pl_x + c_x + bias_x;
    y_d    = sum_x[SHIFT +: OW];
  end

  always_ff @(posedge clk_i) begin
    y_q <= y_d;
  end

  assign y_o = y_q;

endmodule

// ===== src/kelvin_small_argument_top.sv =====
// Kelvin functions ber, bei, ber', bei' for arguments in [-8, 8].
// Each accepted start comes out with done_o; throughput one item per cycle,
// set by the fully pipelined two-stage multipliers of the Horner chains.
// busy stays low: the pipeline takes an item every cycle and the receiver cannot stall.
// Reset (rst_ni low, asynchronous) clears the valid bits only; no other state.
// Depends on ksa_pkg and ksa_mulr.
module kelvin_small_argument_top #(
  parameter int IN_FRAC_BITS  = ksa_pkg::IN_FRAC_DEF,
  parameter int OUT_FRAC_BITS = ksa_pkg::OUT_FRAC_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [ksa_pkg::IN_W-1:0]     x_value_i,
  output logic                                done_o,
  output logic signed [ksa_pkg::OUT_W-1:0]    ber_value_o,
  output logic signed [ksa_pkg::OUT_W-1:0]    bei_value_o,
  output logic signed [ksa_pkg::OUT_W-1:0]    ber_slope_o,
  output logic signed [ksa_pkg::OUT_W-1:0]    bei_slope_o
);

  localparam int T_W   = ksa_pkg::T_W;
  localparam int ACC_W = ksa_pkg::ACC_W;
  localparam int W_W   = ksa_pkg::W_W;
  localparam int OUT_W = ksa_pkg::OUT_W;
  localparam int WF    = ksa_pkg::WF;
  localparam int T_SH  = WF - 3 - IN_FRAC_BITS;
  localparam int OSH   = WF - OUT_FRAC_BITS;
  // t:1, u:2, v:2, ber Horner:14, slope tail:2, output:1
  localparam int LAT   = 22;

  localparam logic signed [31:0]    X_LIM   = 32'sd8 <<< IN_FRAC_BITS;
  localparam logic signed [ACC_W:0] OBIAS_P = (ACC_W+1)'(64'sd1 <<< (OSH - 1));
  localparam logic signed [ACC_W:0] OBIAS_N = (ACC_W+1)'((64'sd1 <<< (OSH - 1)) - 64'sd1);
  localparam logic signed [ACC_W:0] SAT_HI  = (ACC_W+1)'(64'sd8388607);
  localparam logic signed [ACC_W:0] SAT_LO  = (ACC_W+1)'(-64'sd8388608);
  localparam logic signed [OUT_W-1:0] BER_ZERO = (OUT_FRAC_BITS <= 22) ?
      OUT_W'(64'sd1 <<< OUT_FRAC_BITS) : OUT_W'(64'sd8388607);

  // Round Q28 to the output format and saturate
  function automatic logic signed [OUT_W-1:0] to_out(input logic signed [ACC_W-1:0] q);
    logic signed [ACC_W:0] r;
    r = (ACC_W+1)'(q) + (q[ACC_W-1] ? OBIAS_N : OBIAS_P);
    r = r >>> OSH;
    if (r > SAT_HI) begin
      r = SAT_HI;
    end else if (r < SAT_LO) begin
      r = SAT_LO;
    end
    return OUT_W'(r);
  endfunction

  logic                    accept;
  logic [LAT-1:0]          vld_q;
  logic signed [31:0]      xe, xc;
  logic signed [T_W-1:0]   t_d, t_q;
  logic signed [T_W-1:0]   t_dly_q [18];
  logic signed [T_W-1:0]   u_w, v_w;
  logic signed [T_W-1:0]   u_dly_q [14];
  logic signed [T_W-1:0]   v_dly_q [12];
  wire  signed [ACC_W-1:0] ber_acc  [8];
  wire  signed [ACC_W-1:0] bei_acc  [7];
  wire  signed [ACC_W-1:0] berp_acc [7];
  wire  signed [ACC_W-1:0] beip_acc [7];
  logic signed [ACC_W-1:0] bei_w, beip_w, berp_w;
  logic signed [W_W-1:0]   w_w;
  logic signed [ACC_W-1:0] ber_dly_q  [2];
  logic signed [ACC_W-1:0] bei_dly_q  [2];
  logic signed [ACC_W-1:0] beip_dly_q [2];
  logic signed [OUT_W-1:0] ber_q, bei_q, berp_q, beip_q;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Advance valid bits alongside the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LAT-2:0], accept};
    end
  end

  // Clamp x to [-8, 8] and form t = x/8 in Q28
  always_comb begin
    xe = 32'(x_value_i);
    if (xe > X_LIM) begin
      xc = X_LIM;
    end else if (xe < -X_LIM) begin
      xc = -X_LIM;
    end else begin
      xc = xe;
    end
    t_d = T_W'(xc <<< T_SH);
  end

  always_ff @(posedge clk_i) begin
    t_q <= t_d;
  end

  // Delay t, u and v to meet each Horner step and the final products
  always_ff @(posedge clk_i) begin
    t_dly_q[0] <= t_q;
    for (int j = 1; j < 18; j++) begin
      t_dly_q[j] <= t_dly_q[j-1];
    end
    u_dly_q[0] <= u_w;
    for (int j = 1; j < 14; j++) begin
      u_dly_q[j] <= u_dly_q[j-1];
    end
    v_dly_q[0] <= v_w;
    for (int j = 1; j < 12; j++) begin
      v_dly_q[j] <= v_dly_q[j-1];
    end
  end

  // u = t^2, v = t^4
  ksa_mulr #(.AW(T_W), .BW(T_W), .OW(T_W), .SHIFT(WF)) u_mul_u (
    .clk_i(clk_i), .a_i(t_q), .b_i(t_q), .c_i('0), .y_o(u_w)
  );

  ksa_mulr #(.AW(T_W), .BW(T_W), .OW(T_W), .SHIFT(WF)) u_mul_v (
    .clk_i(clk_i), .a_i(u_w), .b_i(u_w), .c_i('0), .y_o(v_w)
  );

  // Horner chains in v, one multiply stage pair per coefficient below the leading one
  assign ber_acc[0]  = ksa_pkg::BER_TAB[7];
  assign bei_acc[0]  = ksa_pkg::BEI_TAB[6];
  assign berp_acc[0] = ksa_pkg::BERP_TAB[6];
  assign beip_acc[0] = ksa_pkg::BEIP_TAB[6];

  for (genvar k = 1; k < 8; k++) begin : g_step
    logic signed [T_W-1:0] vb;
    if (k == 1) begin : g_v0
      assign vb = v_w;
    end else begin : g_vd
      assign vb = v_dly_q[2*k-3];
    end

    ksa_mulr #(.AW(ACC_W), .BW(T_W), .OW(ACC_W), .SHIFT(WF)) u_ber (
      .clk_i(clk_i), .a_i(ber_acc[k-1]), .b_i(vb),
      .c_i(ksa_pkg::BER_TAB[7-k]), .y_o(ber_acc[k])
    );

    if (k < 7) begin : g_six
      ksa_mulr #(.AW(ACC_W), .BW(T_W), .OW(ACC_W), .SHIFT(WF)) u_bei (
        .clk_i(clk_i), .a_i(bei_acc[k-1]), .b_i(vb),
        .c_i(ksa_pkg::BEI_TAB[6-k]), .y_o(bei_acc[k])
      );
      ksa_mulr #(.AW(ACC_W), .BW(T_W), .OW(ACC_W), .SHIFT(WF)) u_berp (
        .clk_i(clk_i), .a_i(berp_acc[k-1]), .b_i(vb),
        .c_i(ksa_pkg::BERP_TAB[6-k]), .y_o(berp_acc[k])
      );
      ksa_mulr #(.AW(ACC_W), .BW(T_W), .OW(ACC_W), .SHIFT(WF)) u_beip (
        .clk_i(clk_i), .a_i(beip_acc[k-1]), .b_i(vb),
        .c_i(ksa_pkg::BEIP_TAB[6-k]), .y_o(beip_acc[k])
      );
    end
  end

  // Scale by u or t after the chains
  ksa_mulr #(.AW(ACC_W), .BW(T_W), .OW(ACC_W), .SHIFT(WF)) u_bei_u (
    .clk_i(clk_i), .a_i(bei_acc[6]), .b_i(u_dly_q[13]), .c_i('0), .y_o(bei_w)
  );

  ksa_mulr #(.AW(ACC_W), .BW(T_W), .OW(W_W), .SHIFT(WF)) u_berp_u (
    .clk_i(clk_i), .a_i(berp_acc[6]), .b_i(u_dly_q[13]), .c_i('0), .y_o(w_w)
  );

  ksa_mulr #(.AW(W_W), .BW(T_W), .OW(ACC_W), .SHIFT(WF - 3)) u_berp_t (
    .clk_i(clk_i), .a_i(w_w), .b_i(t_dly_q[17]), .c_i('0), .y_o(berp_w)
  );

  ksa_mulr #(.AW(ACC_W), .BW(T_W), .OW(ACC_W), .SHIFT(WF - 3)) u_beip_t (
    .clk_i(clk_i), .a_i(beip_acc[6]), .b_i(t_dly_q[15]), .c_i('0), .y_o(beip_w)
  );

  // Align the shorter paths with ber'
  always_ff @(posedge clk_i) begin
    ber_dly_q[0]  <= ber_acc[7];
    ber_dly_q[1]  <= ber_dly_q[0];
    bei_dly_q[0]  <= bei_w;
    bei_dly_q[1]  <= bei_dly_q[0];
    beip_dly_q[0] <= beip_w;
    beip_dly_q[1] <= beip_dly_q[0];
  end

  // Round and saturate into the output registers
  always_ff @(posedge clk_i) begin
    ber_q  <= to_out(ber_dly_q[1]);
    bei_q  <= to_out(bei_dly_q[1]);
    berp_q <= to_out(berp_w);
    beip_q <= to_out(beip_dly_q[1]);
  end

  assign done_o      = vld_q[LAT-1];
  assign ber_value_o = ber_q;
  assign bei_value_o = bei_q;
  assign ber_slope_o = berp_q;
  assign bei_slope_o = beip_q;

`ifndef SYNTHESIS
  // Every result belongs to an item accepted earlier, as traced by the valid bits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy && rst_ni, LAT))
    else $error("done_o without an item accepted LAT cycles earlier");

  // Every accepted item comes out with done_o raised
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(start && !busy && rst_ni, LAT) |-> done_o)
    else $error("item accepted LAT cycles earlier did not raise done_o");

  // A zero argument gives ber = 1 (the largest output value if OUT_FRAC_BITS exceeds 22) and zero for the other three
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(start && !busy && x_value_i == '0, LAT)) |->
    (ber_value_o == BER_ZERO && bei_value_o == '0 &&
     ber_slope_o == '0 && bei_slope_o == '0))
    else $error("wrong results for a zero argument");
`endif

endmodule
